### design/jpd_pkg.sv
// ----------------------------------------------------------------------------
// jpd_pkg
// Shared types and constants for the joint PD duty controller: item codes,
// fixed-point scaling constants and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package jpd_pkg;

	// Number of joints and the index width needed to address them
	localparam int JOINTS = 12;
	localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// Field widths of one item
	localparam int MODE_W  = 3;
	localparam int JOINT_W = 4;
	localparam int POS_W   = 16;
	localparam int DUTY_W  = 11;
	localparam int GAIN_W  = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 1'd1;
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd1280;

	// Item kinds
	localparam logic [MODE_W-1:0] MODE_SAMPLE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TARGET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POSITION = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CUR_KEEP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CUR_DUTY = 3'd4;

	// Torque (20 fraction bits) to tenths of a percent: 58750 / (37 * 2^20)
	localparam longint SCALE_NUM  = 58750;
	localparam longint SCALE_DEN  = 37;
	localparam int     FRAC_SHIFT = 20;
	// Smallest torque magnitude whose scaled duty reaches the limit
	localparam longint DUTY_LIMIT = 700;
	localparam longint SAT_MAG =
		(DUTY_LIMIT * SCALE_DEN * (64'sd1 <<< FRAC_SHIFT) + SCALE_NUM - 1) / SCALE_NUM;
	// Division by 37 as a multiplication by a rounded-up reciprocal
	localparam int     RECIP_SHIFT = 21;
	localparam longint RECIP_MUL   = ((64'sd1 <<< RECIP_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
	localparam int     PCT_LIMIT   = 70;

	// Width of the unsigned magnitude fed to the scaling step and of the quotient
	localparam int MAG_W = 19;
	localparam int QUO_W = 15;
	localparam int ACC_W = 36;

	// Shared multiplier operations
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PROP,
		OP_DERIV,
		OP_ABS,
		OP_SCALE,
		OP_RECIP
	} mul_op_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    exec;
		mul_op_t op;
		logic    emit_pd;
		logic    emit_held;
	} jpd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic sample_ok;
		logic joint_cur;
		logic out_free;
	} jpd_sts_t;

endpackage

### design/jpd_ctrl.sv
// ----------------------------------------------------------------------------
// jpd_ctrl
// Sequencer: takes one item, lets the datapath apply it, steps the shared
// multiplier through the PD computation when needed and outputs any result.
// ----------------------------------------------------------------------------
module jpd_ctrl
	import jpd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  jpd_sts_t sts,
	output jpd_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PROP,
		ST_DERIV,
		ST_ABS,
		ST_SCALE,
		ST_RECIP,
		ST_EMIT_PD,
		ST_EMIT_HELD
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE:      cmd.load = s_tvalid;
			ST_EXEC:      cmd.exec = 1'b1;
			ST_PROP:      cmd.op = OP_PROP;
			ST_DERIV:     cmd.op = OP_DERIV;
			ST_ABS:       cmd.op = OP_ABS;
			ST_SCALE:     cmd.op = OP_SCALE;
			ST_RECIP:     cmd.op = OP_RECIP;
			ST_EMIT_PD:   cmd.emit_pd = sts.out_free;
			ST_EMIT_HELD: cmd.emit_held = sts.out_free;
			default:      cmd.op = OP_NONE;
		endcase
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (!sts.sample_ok) state_q <= ST_IDLE;
					else if (sts.joint_cur) state_q <= ST_EMIT_HELD;
					else state_q <= ST_PROP;
				end
				ST_PROP:  state_q <= ST_DERIV;
				ST_DERIV: state_q <= ST_ABS;
				ST_ABS:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_EMIT_PD;
				ST_EMIT_PD, ST_EMIT_HELD: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/jpd_datapath.sv
// ----------------------------------------------------------------------------
// jpd_datapath
// Per-joint state, gain registers, the shared multiplier with its accumulator,
// duty scaling and saturation, and the output register.
// ----------------------------------------------------------------------------
module jpd_datapath
	import jpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  jpd_cmd_t             cmd,
	output jpd_sts_t             sts,
	input  logic [23:0]          s_tdata,
	input  logic [MODE_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,
	output logic [0:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	// Item held for the duration of its work
	logic [MODE_W-1:0]       mode_q;
	logic [JOINT_W-1:0]      joint_q;
	logic signed [POS_W-1:0] value_q;
	logic [JW-1:0]           jidx;
	logic                    item_ok;

	// Gains
	logic [GAIN_W-1:0] prop_gain_q;
	logic [GAIN_W-1:0] deriv_gain_q;

	// Per-joint state
	logic signed [POS_W-1:0]  target_q [JOINTS];
	logic signed [POS_W-1:0]  last_q   [JOINTS];
	logic signed [POS_W-1:0]  prev_q   [JOINTS];
	logic                     cur_q    [JOINTS];
	logic signed [DUTY_W-1:0] held_q   [JOINTS];

	// Arithmetic
	logic signed [POS_W:0]    err_q;
	logic signed [POS_W:0]    rate_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     neg_q;
	logic                     sat_q;
	logic signed [19:0]       mul_a;
	logic [15:0]              mul_b;
	logic signed [36:0]       product;
	logic signed [ACC_W-1:0]  mag;
	logic signed [7:0]        pct;
	logic signed [DUTY_W-1:0] pct_x;
	logic signed [DUTY_W-1:0] duty_cmd;
	logic [DUTY_W-1:0]        pd_mag;
	logic signed [DUTY_W-1:0] pd_duty;

	// Output register
	logic                     out_valid_q;
	logic [JOINT_W-1:0]       out_joint_q;
	logic signed [DUTY_W-1:0] out_duty_q;
	logic                     out_cur_q;
	logic                     out_free;

	assign jidx    = JW'(joint_q);
	assign item_ok = ({2'b00, joint_q} < 6'(JOINTS)) && (mode_q <= MODE_CUR_DUTY);
	assign out_free = !out_valid_q || m_tready;

	assign sts.sample_ok = item_ok && (mode_q == MODE_SAMPLE);
	assign sts.joint_cur = cur_q[jidx];
	assign sts.out_free  = out_free;

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_tuser;
			joint_q <= s_tdata[3:0];
			value_q <= s_tdata[19:4];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				default:        prop_gain_q  <= prop_gain_q;
			endcase
		end
	end

	// Clamp a commanded duty to the percent limit and convert to tenths
	always_comb begin
		if (value_q > 16'sd70) pct = 8'(PCT_LIMIT);
		else if (value_q < -16'sd70) pct = -8'(PCT_LIMIT);
		else pct = value_q[7:0];
		pct_x    = {{(DUTY_W-8){pct[7]}}, pct};
		duty_cmd = (pct_x <<< 3) + (pct_x <<< 1);
	end

	// Select multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_PROP: begin
				mul_a = 20'(err_q);
				mul_b = prop_gain_q;
			end
			OP_DERIV: begin
				mul_a = 20'(rate_q);
				mul_b = deriv_gain_q;
			end
			OP_SCALE: begin
				mul_a = {1'b0, acc_q[MAG_W-1:0]};
				mul_b = 16'(SCALE_NUM);
			end
			OP_RECIP: begin
				mul_a = {5'b0, acc_q[FRAC_SHIFT+QUO_W-1:FRAC_SHIFT]};
				mul_b = 16'(RECIP_MUL);
			end
			OP_NONE, OP_ABS: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: mul_a = '0;
		endcase
		product = mul_a * $signed({1'b0, mul_b});
		mag     = acc_q[ACC_W-1] ? -acc_q : acc_q;
	end

	// Step the accumulator
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_PROP:  acc_q <= product[ACC_W-1:0];
			OP_DERIV: acc_q <= acc_q - product[ACC_W-1:0];
			OP_ABS: begin
				neg_q <= acc_q[ACC_W-1];
				sat_q <= (mag >= ACC_W'(SAT_MAG));
				acc_q <= mag;
			end
			OP_SCALE: acc_q <= product[ACC_W-1:0];
			OP_RECIP: acc_q <= product[ACC_W-1:0];
			OP_NONE:  acc_q <= acc_q;
			default:  acc_q <= acc_q;
		endcase
	end

	// Saturate, then restore the sign
	always_comb begin
		pd_mag  = sat_q ? DUTY_W'(DUTY_LIMIT)
			: {1'b0, acc_q[RECIP_SHIFT+DUTY_W-2:RECIP_SHIFT]};
		pd_duty = neg_q ? -$signed(pd_mag) : $signed(pd_mag);
	end

	// Per-joint state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				target_q[i] <= '0;
				last_q[i]   <= '0;
				prev_q[i]   <= '0;
				cur_q[i]    <= 1'b0;
				held_q[i]   <= '0;
			end
			err_q  <= '0;
			rate_q <= '0;
		end else begin
			if (cmd.exec && item_ok) begin
				unique case (mode_q)
					MODE_SAMPLE: begin
						last_q[jidx] <= value_q;
						if (!cur_q[jidx]) begin
							prev_q[jidx] <= value_q;
							err_q  <= 17'(target_q[jidx]) - 17'(value_q);
							rate_q <= 17'(value_q) - 17'(prev_q[jidx]);
						end
					end
					MODE_TARGET: target_q[jidx] <= value_q;
					MODE_POSITION: begin
						if (cur_q[jidx]) begin
							cur_q[jidx]    <= 1'b0;
							target_q[jidx] <= last_q[jidx];
							prev_q[jidx]   <= last_q[jidx];
						end
					end
					MODE_CUR_KEEP: cur_q[jidx] <= 1'b1;
					MODE_CUR_DUTY: begin
						cur_q[jidx]  <= 1'b1;
						held_q[jidx] <= duty_cmd;
					end
					default: cur_q[jidx] <= cur_q[jidx];
				endcase
			end
			// Keep the PD result as the joint's held duty
			if (cmd.emit_pd) held_q[jidx] <= pd_duty;
		end
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pd || cmd.emit_held) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pd || cmd.emit_held) begin
			out_joint_q <= joint_q;
			out_duty_q  <= cmd.emit_pd ? pd_duty : held_q[jidx];
			out_cur_q   <= cmd.emit_held;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_duty_q, out_joint_q};
	assign m_tuser  = out_cur_q;

endmodule

### design/joint_pd_duty_controller.sv
// ----------------------------------------------------------------------------
// joint_pd_duty_controller
// PD position controller for a set of motor joints with duty saturation.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one item for one joint. A sample item
// returns the joint's drive duty in tenths of a percent, clamped to +-70
// percent; command items (set target, position mode, current mode) return
// nothing. Items are handled one at a time through a single shared 20x16
// multiplier: a sample for a joint in position mode is loaded, updated, run
// through five accumulator steps and emitted, one for a joint in current mode
// is loaded, updated and emitted, and a command is loaded and updated. The
// result sits in an output register, so the next item is taken while it
// waits; a new result waits for that register to empty.
// ----------------------------------------------------------------------------
module joint_pd_duty_controller
	import jpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [3:0] joint, [19:4] value, [23:20] zero
	input  logic [MODE_W-1:0]    s_tuser,   // [2:0] mode
	// Result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // [3:0] out_joint, [14:4] duty_tenths, [15] zero
	output logic [0:0]           m_tuser,   // [0] in_current_mode
	// Configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);

	jpd_cmd_t cmd;
	jpd_sts_t sts;

	jpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	jpd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
